[rtl/s2c_pkg.sv]
// Package: payload types and CORDIC constants for the spherical-to-Cartesian unit.
`timescale 1ns / 1ps
`default_nettype none
package s2c_pkg;

    localparam int unsigned AtanEntries = 24;
    localparam int unsigned AngW        = 34;
    localparam int unsigned TrigW       = 34;

    localparam logic signed [AngW-1:0] GainQ30   = 34'sd652032874;
    localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;
    localparam logic signed [AngW-1:0] PiQ30     = 34'sd3373259426;
    localparam logic signed [63:0]     RoundQ30  = 64'sd536870912;

    typedef struct packed {
        logic signed [15:0] incl_low;
        logic signed [15:0] incl_high;
        logic signed [15:0] azim_low;
        logic signed [15:0] azim_high;
        logic signed [31:0] radial_comp;
        logic signed [31:0] polar_comp;
        logic signed [31:0] azimuthal_comp;
    } t_s2c_in;

    typedef struct packed {
        logic signed [31:0] x_comp;
        logic signed [31:0] y_comp;
        logic signed [31:0] z_comp;
    } t_s2c_out;

    typedef struct packed {
        logic signed [31:0] r;
        logic signed [31:0] p;
        logic signed [31:0] a;
    } t_s2c_vec;

    function automatic logic signed [AngW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [AngW-1:0] v;
        case (idx)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round a Q.30 product sum to integer, ties up.
    function automatic logic signed [63:0] round_q30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'(RoundQ30);
        return 64'(t >>> 30);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] o;
        if (v > 64'sd2147483647)       o = 32'sh7fffffff;
        else if (v < -64'sd2147483648) o = 32'sh80000000;
        else                           o = v[31:0];
        return o;
    endfunction

endpackage
`default_nettype wire

[rtl/spherical_to_cartesian_vector_unit.sv]
// Top level: spherical-to-Cartesian vector conversion pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Takes one transaction per clock: busy is always low, so every cycle with
// start high enters a cell. Each cell runs CORDIC_STEPS+1 angle stages (both
// mid angles in parallel CORDIC pipelines, capped at 24 steps) and then four
// multiply/round stages, so its result strobes on o_done as it leaves the
// final multiply/round stage. The receiver cannot stall; results are
// given once, in order, and must be taken on the strobe.
module spherical_to_cartesian_vector_unit #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  s2c_pkg::t_s2c_in  i_item,
    output logic               o_done,
    output s2c_pkg::t_s2c_out  o_result
);
    localparam int unsigned N   = (CORDIC_STEPS > s2c_pkg::AtanEntries) ?
                                  s2c_pkg::AtanEntries : CORDIC_STEPS;
    localparam int unsigned LAT = N + 5;

    logic signed [s2c_pkg::TrigW-1:0] st, ct, sp, cp;
    s2c_pkg::t_s2c_vec r_vec [0:N];
    logic [LAT-1:0] r_vld;

    // Never hold off the source; the pipeline advances every cycle.
    assign busy = 1'b0;

    s2c_cordic #(.STEPS(CORDIC_STEPS)) u_theta (
        .i_clk(i_clk), .i_en(1'b1), .i_lo(i_item.incl_low), .i_hi(i_item.incl_high),
        .o_sin(st), .o_cos(ct)
    );
    s2c_cordic #(.STEPS(CORDIC_STEPS)) u_phi (
        .i_clk(i_clk), .i_en(1'b1), .i_lo(i_item.azim_low), .i_hi(i_item.azim_high),
        .o_sin(sp), .o_cos(cp)
    );

    // Carry the vector alongside the CORDIC stages.
    always_ff @(posedge i_clk) begin
        r_vec[0] <= '{r: i_item.radial_comp, p: i_item.polar_comp, a: i_item.azimuthal_comp};
        for (int k = 0; k < N; k++) r_vec[k+1] <= r_vec[k];
    end

    s2c_rotate u_rot (
        .i_clk(i_clk), .i_en(1'b1), .i_vec(r_vec[N]),
        .i_st(st), .i_ct(ct), .i_sp(sp), .i_cp(cp), .o_res(o_result)
    );

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    assign o_done = r_vld[LAT-1];
endmodule
`default_nettype wire

[rtl/s2c_cordic.sv]
// Module: pipelined rotation-mode CORDIC giving sin and cos of a mid angle, one stage per step.
`timescale 1ns / 1ps
`default_nettype none
module s2c_cordic #(
    parameter int unsigned STEPS = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire  signed [15:0]                  i_lo,
    input  wire  signed [15:0]                  i_hi,
    output logic signed [s2c_pkg::TrigW-1:0]    o_sin,
    output logic signed [s2c_pkg::TrigW-1:0]    o_cos
);
    localparam int unsigned N = (STEPS > s2c_pkg::AtanEntries) ? s2c_pkg::AtanEntries : STEPS;
    localparam int unsigned W = s2c_pkg::AngW;

    logic signed [W-1:0] r_x [0:N];
    logic signed [W-1:0] r_y [0:N];
    logic signed [W-1:0] r_z [0:N];
    logic                r_neg [0:N];

    logic signed [16:0] mid_sum;
    logic signed [W-1:0] mid_q30;
    logic signed [W-1:0] n_z0;
    logic                n_neg0;

    always_comb begin
        mid_sum = 17'(i_lo) + 17'(i_hi);
        mid_q30 = W'(mid_sum >>> 1) <<< 17;
        n_neg0  = 1'b0;
        n_z0    = mid_q30;
        if (mid_q30 > s2c_pkg::HalfPiQ30) begin
            n_z0 = mid_q30 - s2c_pkg::PiQ30;
            n_neg0 = 1'b1;
        end else if (mid_q30 < -s2c_pkg::HalfPiQ30) begin
            n_z0 = mid_q30 + s2c_pkg::PiQ30;
            n_neg0 = 1'b1;
        end
    end

    // Stage 0: reduce the angle into [-pi/2, pi/2].
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= s2c_pkg::GainQ30;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (!r_z[g][W-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - s2c_pkg::atan_q30(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + s2c_pkg::atan_q30(5'(g));
                end
            end
        end
    end

    assign o_sin = r_neg[N] ? -r_y[N] : r_y[N];
    assign o_cos = r_neg[N] ? -r_x[N] : r_x[N];
endmodule
`default_nettype wire

[rtl/s2c_rotate.sv]
// Module: pipelined multiply-round-saturate rotation of the spherical vector into x, y, z.
`timescale 1ns / 1ps
`default_nettype none
module s2c_rotate (
    input  wire                              i_clk,
    input  wire                              i_en,
    input  wire  s2c_pkg::t_s2c_vec          i_vec,
    input  wire  signed [s2c_pkg::TrigW-1:0] i_st,
    input  wire  signed [s2c_pkg::TrigW-1:0] i_ct,
    input  wire  signed [s2c_pkg::TrigW-1:0] i_sp,
    input  wire  signed [s2c_pkg::TrigW-1:0] i_cp,
    output s2c_pkg::t_s2c_out                o_res
);
    // Stage A: theta products.
    logic signed [65:0] r_rst, r_pct, r_rct, r_pst;
    logic signed [31:0] r_a1;
    logic signed [s2c_pkg::TrigW-1:0] r_sp1, r_cp1;
    // Stage B: h and z. |r*sin + p*cos| stays below 2^32, so h fits 34 bits.
    logic signed [33:0] r_h;
    logic signed [63:0] r_z2;
    logic signed [31:0] r_a2;
    logic signed [s2c_pkg::TrigW-1:0] r_sp2, r_cp2;
    // Stage C: phi products.
    logic signed [97:0] r_hcp, r_hsp, r_asp, r_acp;
    logic signed [63:0] r_z3;

    // Round, then clamp to +/-2^32 in the 64-bit result so saturation still sees the sign.
    function automatic logic signed [63:0] rnd98(input logic signed [97:0] v);
        logic signed [97:0] t;
        t = (v + 98'sd536870912) >>> 30;
        if (t > 98'sd4294967296)       return 64'sd4294967296;
        else if (t < -98'sd4294967296) return -64'sd4294967296;
        else                           return t[63:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rst <= 66'(i_vec.r) * 66'(i_st);
            r_pct <= 66'(i_vec.p) * 66'(i_ct);
            r_rct <= 66'(i_vec.r) * 66'(i_ct);
            r_pst <= 66'(i_vec.p) * 66'(i_st);
            r_a1  <= i_vec.a;
            r_sp1 <= i_sp;
            r_cp1 <= i_cp;

            r_h   <= 34'(s2c_pkg::round_q30(r_rst + r_pct));
            r_z2  <= s2c_pkg::round_q30(r_rct - r_pst);
            r_a2  <= r_a1;
            r_sp2 <= r_sp1;
            r_cp2 <= r_cp1;

            r_hcp <= 98'(r_h) * 98'(r_cp2);
            r_hsp <= 98'(r_h) * 98'(r_sp2);
            r_asp <= 98'(r_a2) * 98'(r_sp2);
            r_acp <= 98'(r_a2) * 98'(r_cp2);
            r_z3  <= r_z2;

            o_res.x_comp <= s2c_pkg::sat32(rnd98(r_hcp - r_asp));
            o_res.y_comp <= s2c_pkg::sat32(rnd98(r_hsp + r_acp));
            o_res.z_comp <= s2c_pkg::sat32(r_z3);
        end
    end
endmodule
`default_nettype wire

[rtl/s2c_checker.sv]
// Checker: port-level assertions for the conversion unit, with bind.
`timescale 1ns / 1ps
`default_nettype none
module s2c_checker #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input wire i_clk,
    input wire i_rst_n,
    input wire start,
    input wire busy,
    input wire o_done
);
    localparam int unsigned LAT = ((CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS) + 5;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("result missing");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n, LAT)) |-> $past(start && !busy, LAT))
        else $error("spurious result");
endmodule

bind spherical_to_cartesian_vector_unit s2c_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done)
);
`default_nettype wire
